FILE: hdl/idm_pkg.sv
package idm_pkg;

	// Operand and result widths.
	localparam int WORD_W = 128;
	localparam int HALF_W = 64;

	// One quotient bit is produced per iteration.
	localparam int STEP_CNT_W = 7;
	localparam logic [STEP_CNT_W-1:0] LAST_STEP = 7'd127;

	// Operation codes carried on the cmd port.
	localparam logic [1:0] CMD_UDIV = 2'd0;
	localparam logic [1:0] CMD_UMOD = 2'd1;
	localparam logic [1:0] CMD_SDIV = 2'd2;
	localparam logic [1:0] CMD_SMOD = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic negate;
		logic step;
		logic finish;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic zero;
	} dp_status_t;

endpackage

FILE: hdl/int128_divide_modulo.sv
// 128-bit integer divide and modulo, unsigned or signed (truncating toward
// zero, remainder with the dividend's sign). Raise start for one cycle while
// busy is low to launch a transaction; operands and cmd are sampled at that
// edge. The result appears on result_lo, result_hi and zero_divisor for
// exactly one cycle marked by done and must be captured then, since the
// receiver cannot stall; the ports then hold their value until the next
// transaction completes. From the accepting edge a transaction forms the
// operand magnitudes, runs the radix-2 restoring loop (one quotient bit per
// cycle through a single 129-bit subtractor) and applies sign correction
// into the output register. A zero divisor skips the loop; the quotient is
// then 0, the remainder is the dividend and zero_divisor is set.
// busy drops in the done cycle, so the next start may be taken there.
module int128_divide_modulo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 cmd,
	input  logic [idm_pkg::HALF_W-1:0] dividend_lo,
	input  logic [idm_pkg::HALF_W-1:0] dividend_hi,
	input  logic [idm_pkg::HALF_W-1:0] divisor_lo,
	input  logic [idm_pkg::HALF_W-1:0] divisor_hi,
	output logic                       done,
	output logic [idm_pkg::HALF_W-1:0] result_lo,
	output logic [idm_pkg::HALF_W-1:0] result_hi,
	output logic                       zero_divisor
);
	import idm_pkg::*;

	dp_cmd_t    dp_cmd;
	dp_status_t dp_status;

	// Sequencer.
	idm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.done      (done),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status)
	);

	// Shift-subtract datapath.
	idm_datapath u_datapath (
		.clk          (clk),
		.dp_cmd       (dp_cmd),
		.dp_status    (dp_status),
		.cmd          (cmd),
		.dividend_lo  (dividend_lo),
		.dividend_hi  (dividend_hi),
		.divisor_lo   (divisor_lo),
		.divisor_hi   (divisor_hi),
		.result_lo    (result_lo),
		.result_hi    (result_hi),
		.zero_divisor (zero_divisor)
	);

endmodule

FILE: hdl/idm_datapath.sv
module idm_datapath (
	input  logic                     clk,
	input  idm_pkg::dp_cmd_t         dp_cmd,
	output idm_pkg::dp_status_t      dp_status,
	input  logic [1:0]               cmd,
	input  logic [idm_pkg::HALF_W-1:0] dividend_lo,
	input  logic [idm_pkg::HALF_W-1:0] dividend_hi,
	input  logic [idm_pkg::HALF_W-1:0] divisor_lo,
	input  logic [idm_pkg::HALF_W-1:0] divisor_hi,
	output logic [idm_pkg::HALF_W-1:0] result_lo,
	output logic [idm_pkg::HALF_W-1:0] result_hi,
	output logic                     zero_divisor
);
	import idm_pkg::*;

	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] div_q;
	logic              neg_a_q;
	logic              neg_b_q;
	logic              want_mod_q;
	logic              zero_q;
	logic [WORD_W-1:0] result_q;

	logic              is_signed;
	logic              want_mod;
	logic [WORD_W-1:0] rem_shift;
	logic [WORD_W:0]   diff;
	logic              take;
	logic [WORD_W-1:0] fix_src;
	logic              fix_neg;
	logic [WORD_W-1:0] fix_val;

	// Decode the operation of the incoming transaction.
	always_comb begin
		is_signed = (cmd == CMD_SDIV) || (cmd == CMD_SMOD);
		want_mod  = (cmd == CMD_UMOD) || (cmd == CMD_SMOD);
	end

	// One restoring step: shift the next dividend bit into the remainder and
	// subtract the divisor when it fits. The bit shifted out of the remainder
	// guarantees a fit, so it heads the 129-bit difference.
	always_comb begin
		rem_shift = {rem_q[WORD_W-2:0], quo_q[WORD_W-1]};
		diff      = {rem_q[WORD_W-1], rem_shift} - {1'b0, div_q};
		take      = ~diff[WORD_W];
	end

	// Select quotient or remainder and apply the sign. With a zero divisor
	// the quotient is zero and the remainder is the dividend magnitude,
	// which still sits in the quotient register.
	always_comb begin
		if (zero_q) begin
			fix_src = want_mod_q ? quo_q : '0;
		end else begin
			fix_src = want_mod_q ? rem_q : quo_q;
		end
		fix_neg = want_mod_q ? neg_a_q : (neg_a_q ^ neg_b_q);
		fix_val = fix_neg ? (~fix_src + WORD_W'(1)) : fix_src;
	end

	// Operand, remainder and quotient registers.
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			quo_q      <= {dividend_hi, dividend_lo};
			div_q      <= {divisor_hi, divisor_lo};
			rem_q      <= '0;
			neg_a_q    <= is_signed & dividend_hi[HALF_W-1];
			neg_b_q    <= is_signed & divisor_hi[HALF_W-1];
			want_mod_q <= want_mod;
			zero_q     <= ({divisor_hi, divisor_lo} == '0);
		end else if (dp_cmd.negate) begin
			if (neg_a_q) begin
				quo_q <= ~quo_q + WORD_W'(1);
			end
			if (neg_b_q) begin
				div_q <= ~div_q + WORD_W'(1);
			end
		end else if (dp_cmd.step) begin
			rem_q <= take ? diff[WORD_W-1:0] : rem_shift;
			quo_q <= {quo_q[WORD_W-2:0], take};
		end
	end

	// Result register, held until the next transaction finishes.
	always_ff @(posedge clk) begin
		if (dp_cmd.finish) begin
			result_q     <= fix_val;
			zero_divisor <= zero_q;
		end
	end

	assign result_lo      = result_q[HALF_W-1:0];
	assign result_hi      = result_q[WORD_W-1:HALF_W];
	assign dp_status.zero = zero_q;

endmodule

FILE: hdl/idm_ctrl.sv
module idm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output idm_pkg::dp_cmd_t    dp_cmd,
	input  idm_pkg::dp_status_t dp_status
);
	import idm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_NEG,
		S_ITER,
		S_FIX
	} state_t;

	state_t                state_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic                  done_q;

	// Sequence: load, take magnitudes, iterate (skipped for a zero divisor), fix sign and deliver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_NEG;
					end
				end
				S_NEG: begin
					cnt_q   <= '0;
					state_q <= dp_status.zero ? S_FIX : S_ITER;
				end
				S_ITER: begin
					cnt_q <= cnt_q + STEP_CNT_W'(1);
					if (cnt_q == LAST_STEP) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath commands decoded from the state.
	always_comb begin
		dp_cmd.load   = (state_q == S_IDLE) && start;
		dp_cmd.negate = (state_q == S_NEG);
		dp_cmd.step   = (state_q == S_ITER);
		dp_cmd.finish = (state_q == S_FIX);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

`ifndef SYNTHESIS
	a_start_begins: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == S_IDLE) |=> (state_q == S_NEG))
		else $error("accepted transaction did not begin");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == S_IDLE && $past(state_q) == S_FIX))
		else $error("result strobe outside of completion");
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ITER && cnt_q == LAST_STEP) |=> (state_q == S_FIX))
		else $error("iteration did not end after the last quotient bit");
	a_zero_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_NEG && dp_status.zero) |=> (state_q == S_FIX))
		else $error("zero divisor did not skip the iterations");
`endif

endmodule

FILE: tb/int128_divide_modulo_checker.sv
`timescale 1ns / 100ps

// Watches the command and result channels of the divider, predicts each
// quotient or remainder and compares it with what the block delivers.
module int128_divide_modulo_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       busy,
	input  logic [1:0]                 cmd,
	input  logic [idm_pkg::HALF_W-1:0] dividend_lo,
	input  logic [idm_pkg::HALF_W-1:0] dividend_hi,
	input  logic [idm_pkg::HALF_W-1:0] divisor_lo,
	input  logic [idm_pkg::HALF_W-1:0] divisor_hi,
	input  logic                       done,
	input  logic [idm_pkg::HALF_W-1:0] result_lo,
	input  logic [idm_pkg::HALF_W-1:0] result_hi,
	input  logic                       zero_divisor,
	output int                         mismatch_count,
	output int                         outstanding
);

	import idm_pkg::*;

	typedef struct packed {
		logic [HALF_W-1:0] lo;
		logic [HALF_W-1:0] hi;
		logic              zero;
	} divmod_word_t;

	divmod_word_t expected_results[$];

	// Divides the magnitudes, then restores the signs: the quotient is negated
	// when exactly one operand is negative, the remainder follows the dividend.
	// A zero divisor gives quotient zero and leaves the dividend as remainder.
	function automatic divmod_word_t divmod_result(logic [1:0] op, logic [WORD_W-1:0] num,
			logic [WORD_W-1:0] den);
		logic              is_signed;
		logic              neg_num;
		logic              neg_den;
		logic [WORD_W-1:0] mag_num;
		logic [WORD_W-1:0] mag_den;
		logic [WORD_W-1:0] quo;
		logic [WORD_W-1:0] rem;
		logic [WORD_W-1:0] pick;
		divmod_word_t      res;
		is_signed = (op == CMD_SDIV) || (op == CMD_SMOD);
		neg_num = is_signed && num[WORD_W-1];
		neg_den = is_signed && den[WORD_W-1];
		mag_num = neg_num ? -num : num;
		mag_den = neg_den ? -den : den;
		if (den == '0) begin
			quo = '0;
			rem = mag_num;
		end else begin
			quo = mag_num / mag_den;
			rem = mag_num % mag_den;
		end
		if (neg_num != neg_den)
			quo = -quo;
		if (neg_num)
			rem = -rem;
		pick = (op == CMD_UMOD || op == CMD_SMOD) ? rem : quo;
		res.lo = pick[HALF_W-1:0];
		res.hi = pick[WORD_W-1:HALF_W];
		res.zero = (den == '0);
		return res;
	endfunction

	initial begin
		mismatch_count = 0;
		outstanding = 0;
	end

	// A result is compared before a transaction accepted at the same edge is
	// queued, since busy drops in the done cycle of the previous one.
	always @(posedge clk) begin
		divmod_word_t want;
		if (arst_n) begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result with no transaction waiting: lo %h hi %h zero %b",
						result_lo, result_hi, zero_divisor);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = expected_results.pop_front();
					if (result_lo !== want.lo || result_hi !== want.hi ||
							zero_divisor !== want.zero) begin
						if (result_lo !== want.lo)
							$error("result_lo: expected %h, actual %h", want.lo, result_lo);
						if (result_hi !== want.hi)
							$error("result_hi: expected %h, actual %h", want.hi, result_hi);
						if (zero_divisor !== want.zero)
							$error("zero_divisor: expected %b, actual %b", want.zero,
								zero_divisor);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end
			if (start && !busy)
				expected_results.push_back(divmod_result(cmd, {dividend_hi, dividend_lo},
					{divisor_hi, divisor_lo}));
		end
		outstanding <= expected_results.size();
	end

endmodule

FILE: tb/int128_divide_modulo_test.sv
`timescale 1ns / 100ps

// Drives divide and modulo transactions into the block and gives the verdict;
// all prediction and comparison sits in the checker beside it.
module int128_divide_modulo_test;

	import idm_pkg::*;

	localparam int RANDOM_OPS = 1500;
	localparam int QUIET_TAIL = 300;
	localparam int DRAIN_CYCLES = 140;
	localparam int WATCHDOG_LIMIT = 2000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [1:0]        cmd = CMD_UDIV;
	logic [HALF_W-1:0] dividend_lo = '0;
	logic [HALF_W-1:0] dividend_hi = '0;
	logic [HALF_W-1:0] divisor_lo = '0;
	logic [HALF_W-1:0] divisor_hi = '0;
	logic              busy;
	logic              done;
	logic [HALF_W-1:0] result_lo;
	logic [HALF_W-1:0] result_hi;
	logic              zero_divisor;
	int                mismatch_count;
	int                outstanding;
	int                issued_count = 0;
	int                zero_div_count = 0;
	int                op_count[4] = '{0, 0, 0, 0};
	int                idle_cycles = 0;
	bit                idle_enabled = 1'b1;

	int128_divide_modulo dut (.*);

	int128_divide_modulo_checker checker_inst (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	// Ends the run when neither side moves a transaction for too long.
	always @(posedge clk) begin
		if ((arst_n && start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Presents one transaction and returns at the edge that accepts it. An idle
	// burst starts either at once or when the block frees up, so that gaps land
	// on the done cycle as well as inside the loop.
	task automatic issue(logic [1:0] op, logic [WORD_W-1:0] num, logic [WORD_W-1:0] den);
		int gap;
		if (idle_enabled && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			if ($urandom_range(0, 1) == 0) begin
				do
					@(posedge clk);
				while (busy);
			end
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= op;
		dividend_lo <= num[HALF_W-1:0];
		dividend_hi <= num[WORD_W-1:HALF_W];
		divisor_lo <= den[HALF_W-1:0];
		divisor_hi <= den[WORD_W-1:HALF_W];
		do
			@(posedge clk);
		while (busy);
		issued_count++;
		op_count[op]++;
		if (den == '0)
			zero_div_count++;
	endtask

	// Random operand drawn from a mix of corner values, random bit widths,
	// negated values of random bit width and fully random words.
	function automatic logic [WORD_W-1:0] random_operand();
		logic [WORD_W-1:0] v;
		int                w;
		v = {$urandom, $urandom, $urandom, $urandom};
		w = $urandom_range(1, WORD_W);
		case ($urandom_range(0, 15))
			0: v = '0;
			1: v = '1;
			2: v = {1'b1, {(WORD_W-1){1'b0}}};
			3: v = {1'b0, {(WORD_W-1){1'b1}}};
			4: v = 128'd1 << $urandom_range(0, WORD_W-1);
			5: v = 128'd1;
			6, 7, 8: v = v >> (WORD_W - w);
			9, 10: v = -(v >> (WORD_W - w));
			default: ;
		endcase
		return v;
	endfunction

	initial begin
		logic [WORD_W-1:0] min_val;
		logic [WORD_W-1:0] max_val;
		logic [1:0]        op;
		min_val = {1'b1, {(WORD_W-1){1'b0}}};
		max_val = {1'b0, {(WORD_W-1){1'b1}}};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners, each under all four commands.
		for (int k = 0; k < 4; k++) begin
			op = k[1:0];
			issue(op, '0, '0);
			issue(op, min_val, '0);
			issue(op, '1, 128'd1);
			issue(op, min_val, '1);
			issue(op, {64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef}, 128'd7);
			issue(op, 128'd100, -128'd7);
		end
		issue(CMD_SDIV, -128'd100, -128'd7);
		issue(CMD_SMOD, -128'd100, -128'd7);
		issue(CMD_UDIV, 128'd5, '1);
		issue(CMD_UMOD, max_val, 128'd1 << 64);

		// Random transactions; idling comes and goes in stretches and stops
		// for the final part of the run.
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n % 50 == 0)
				idle_enabled = (n < RANDOM_OPS - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
			op = 2'($urandom_range(0, 3));
			issue(op, random_operand(), random_operand());
		end

		// Drain whatever is still in flight, then allow for a late stray result.
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d transactions: %0d udiv, %0d umod, %0d sdiv, %0d smod.",
			issued_count, op_count[CMD_UDIV], op_count[CMD_UMOD], op_count[CMD_SDIV],
			op_count[CMD_SMOD]);
		$display("%0d had a zero divisor; %0d checks failed.", zero_div_count, mismatch_count);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/idm_pkg.sv
hdl/idm_datapath.sv
hdl/idm_ctrl.sv
hdl/int128_divide_modulo.sv
tb/int128_divide_modulo_checker.sv
tb/int128_divide_modulo_test.sv
